@@ sv/hps_pkg.sv @@
package hps_pkg;

	localparam int MaxCols  = 256;
	localparam int TempBits = 16;
	localparam int ColBits  = 8;
	localparam int RowBits  = 12;
	localparam int SumBits  = 37;
	localparam int AddrBits = 5;

	localparam logic [AddrBits-1:0] RegCols      = 5'd0;
	localparam logic [AddrBits-1:0] RegRows      = 5'd4;
	localparam logic [AddrBits-1:0] RegAmbient   = 5'd8;
	localparam logic [AddrBits-1:0] RegCoolStart = 5'd12;
	localparam logic [AddrBits-1:0] RegCoolEnd   = 5'd16;
	localparam logic [AddrBits-1:0] RegInject    = 5'd20;
	localparam logic [AddrBits-1:0] RegCool      = 5'd24;
	localparam logic [AddrBits-1:0] RegDiffuse   = 5'd28;

	typedef struct packed {
		logic [8:0]  cols;
		logic [12:0] rows;
		logic [15:0] ambient;
		logic [7:0]  cool_start;
		logic [7:0]  cool_end;
		logic [15:0] inject_gain;
		logic [15:0] cool_gain;
		logic [12:0] diffuse_gain;
	} cfg_t;

	// controller commands to datapath
	typedef struct packed {
		logic       load;    // capture input item, compute position
		logic       adv1;    // injection stage
		logic       adv2;    // cooling stage
		logic       adv3;    // stencil neighbour sum stage
		logic       adv4;    // final stage, write lines and result
	} cmd_t;

	typedef struct packed {
		logic emit;  // current item produces a result
	} sts_t;

	// rounded gain product of a magnitude, q0.16 gain
	function automatic logic [TempBits+2:0] gain_mul(input logic [TempBits+2:0] mag,
			input logic [15:0] gain);
		logic [TempBits+34:0] p;
		begin
			p = 35'(mag) * 35'(gain) + 51'd32768;
			gain_mul = p[TempBits+18:16];
		end
	endfunction

endpackage

@@ sv/hps_if.sv @@
interface hps_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_temp;
	logic [15:0] chip_temp;
	modport source (output valid, cell_temp, chip_temp, input ready);
	modport sink (input valid, cell_temp, chip_temp, output ready);
endinterface

interface hps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] new_temp;
	logic [11:0] cell_row;
	logic [7:0]  cell_col;
	logic [36:0] running_sum;
	logic        last_cell;
	modport source (output valid, new_temp, cell_row, cell_col, running_sum, last_cell,
		input ready);
	modport sink (input valid, new_temp, cell_row, cell_col, running_sum, last_cell,
		output ready);
endinterface

@@ sv/hps_ram.sv @@
module hps_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/hps_ctrl.sv @@
module hps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  hps_pkg::sts_t     sts,
	output hps_pkg::cmd_t     cmd
);
	typedef enum logic [5:0] {
		IDLE = 6'b000001,
		ST1  = 6'b000010,
		ST2  = 6'b000100,
		ST3  = 6'b001000,
		ST4  = 6'b010000,
		HOLD = 6'b100000
	} state_t;

	state_t state_q;
	logic   outv_q;

	// next item enters whenever the sequencer is idle; a waiting result holds it in ST4
	assign in_ready  = (state_q == IDLE);
	assign out_valid = outv_q;

	always_comb begin
		cmd      = '0;
		cmd.load = in_valid && in_ready;
		cmd.adv1 = (state_q == ST1);
		cmd.adv2 = (state_q == ST2);
		cmd.adv3 = (state_q == ST3);
		cmd.adv4 = (state_q == ST4) && (!outv_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			outv_q  <= 1'b0;
		end else begin
			if (out_ready) outv_q <= 1'b0;
			case (state_q)
				IDLE: if (cmd.load) state_q <= ST1;
				ST1:  state_q <= ST2;
				ST2:  state_q <= ST3;
				ST3:  state_q <= ST4;
				ST4: begin
					if (cmd.adv4) begin
						state_q <= IDLE;
						if (sts.emit) outv_q <= 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

@@ sv/hps_dp.sv @@
module hps_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  hps_pkg::cfg_t     cfg,
	input  hps_pkg::cmd_t     cmd,
	output hps_pkg::sts_t     sts,
	input  logic [15:0]       cell_temp,
	input  logic [15:0]       chip_temp,
	output logic [15:0]       new_temp,
	output logic [11:0]       cell_row,
	output logic [7:0]        cell_col,
	output logic [36:0]       running_sum,
	output logic              last_cell
);
	logic [11:0] row_q;
	logic [7:0]  col_q;
	logic [36:0] sum_q;
	logic [15:0] w_q [6];

	logic [8:0]  cols;
	logic [12:0] rows;
	logic [11:0] r;
	logic [7:0]  c;
	logic        interior;

	logic [15:0] t_q, chip_q;
	logic [11:0] r_q;
	logic [7:0]  c_q;
	logic        int_q, emit_q, last_q, clr_q, wrap_c_q, wrap_r_q;
	logic [15:0] up_rd, mid_rd;
	logic [18:0] s8_q, c8_q;
	logic [15:0] stencil_res;

	// clamp sizes and position, flag interior cells
	always_comb begin
		cols = cfg.cols;
		if (cols < 9'd3) cols = 9'd3;
		if (cols > 9'd256) cols = 9'd256;
		rows = cfg.rows;
		if (rows < 13'd3) rows = 13'd3;
		if (rows > 13'd4096) rows = 13'd4096;
		c = (9'(col_q) >= cols) ? 8'(cols - 9'd1) : col_q;
		r = (13'(row_q) >= rows) ? 12'(rows - 13'd1) : row_q;
		interior = (r >= 12'd1) && (13'(r) <= rows - 13'd2) && (c >= 8'd1)
			&& (9'(c) <= cols - 9'd2);
	end

	hps_ram #(.Width(16), .Depth(hps_pkg::MaxCols)) u_upper (
		.clk(clk), .we(cmd.adv4), .waddr(c_q), .wdata(mid_rd),
		.raddr(c), .rdata(up_rd));
	hps_ram #(.Width(16), .Depth(hps_pkg::MaxCols)) u_middle (
		.clk(clk), .we(cmd.adv4), .waddr(c_q), .wdata(t_q),
		.raddr(c), .rdata(mid_rd));

	// movement toward a target, saturated
	function automatic logic [15:0] move16(input logic [15:0] v, input logic [15:0] tg,
			input logic [15:0] g);
		logic [18:0] d;
		logic [19:0] s;
		begin
			if (tg >= v) begin
				d = hps_pkg::gain_mul(19'(tg - v), g);
				s = 20'(v) + 20'(d);
				move16 = (s > 20'hFFFF) ? 16'hFFFF : s[15:0];
			end else begin
				d = hps_pkg::gain_mul(19'(v - tg), g);
				move16 = (d > 19'(v)) ? 16'd0 : 16'(19'(v) - d);
			end
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q    <= cell_temp;
			chip_q <= chip_temp;
			r_q    <= r;
			c_q    <= c;
			int_q  <= interior;
			emit_q <= (r >= 12'd2) && (c >= 8'd2);
			last_q <= (13'(r) == rows - 13'd1) && (9'(c) == cols - 9'd1);
			clr_q  <= (r == 12'd0) && (c == 8'd0);
			wrap_c_q <= (9'(c) >= cols - 9'd1);
			wrap_r_q <= (13'(r) >= rows - 13'd1);
		end
		if (cmd.adv1 && int_q && chip_q > t_q)
			t_q <= move16(t_q, chip_q, cfg.inject_gain);
		if (cmd.adv2) begin
			if (int_q && c_q >= cfg.cool_start && c_q < cfg.cool_end)
				t_q <= move16(t_q, cfg.ambient, cfg.cool_gain);
		end
		if (cmd.adv3) begin
			s8_q <= 19'(w_q[0]) + 19'(w_q[1]) + 19'(up_rd) + 19'(w_q[2]) + 19'(mid_rd)
				+ 19'(w_q[4]) + 19'(w_q[5]) + 19'(t_q);
			c8_q <= {w_q[3], 3'b000};
		end
	end

	// stencil result from registered sums
	always_comb begin
		logic [18:0] d;
		logic [19:0] s;
		d = '0;
		s = '0;
		if (s8_q >= c8_q) begin
			d = hps_pkg::gain_mul(s8_q - c8_q, 16'(cfg.diffuse_gain));
			s = 20'(w_q[3]) + 20'(d);
			stencil_res = (s > 20'hFFFF) ? 16'hFFFF : s[15:0];
		end else begin
			d = hps_pkg::gain_mul(c8_q - s8_q, 16'(cfg.diffuse_gain));
			stencil_res = (d > 19'(w_q[3])) ? 16'd0 : 16'(19'(w_q[3]) - d);
		end
	end

	assign sts.emit = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < 6; i++) w_q[i] <= '0;
		end else if (cmd.adv4) begin
			if (emit_q) sum_q <= (clr_q ? 37'd0 : sum_q) + 37'(stencil_res);
			else if (clr_q) sum_q <= '0;
			w_q[0] <= w_q[1]; w_q[1] <= up_rd;
			w_q[2] <= w_q[3]; w_q[3] <= mid_rd;
			w_q[4] <= w_q[5]; w_q[5] <= t_q;
			if (wrap_c_q) begin
				col_q <= '0;
				row_q <= wrap_r_q ? 12'd0 : r_q + 12'd1;
			end else begin
				col_q <= c_q + 8'd1;
				row_q <= r_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv4 && emit_q) begin
			new_temp    <= stencil_res;
			cell_row    <= r_q - 12'd1;
			cell_col    <= c_q - 8'd1;
			running_sum <= (clr_q ? 37'd0 : sum_q) + 37'(stencil_res);
			last_cell   <= last_q;
		end
	end
endmodule

@@ sv/heat_plate_stencil_step.sv @@
// the controller walks each accepted item through injection, cooling, neighbour sum
// and gain/write-back states in turn, and its result, if any, is registered on the output;
// a new item is taken only after the previous one has left its write-back state
// a result not yet taken holds the following item in its write-back state
// reset: arst_n clears counters, window, running sum and registers to defaults;
// the line buffers hold no reset and are filled by the first two rows of a pass
module heat_plate_stencil_step (
	input  logic              clk,
	input  logic              arst_n,
	hps_in_if.sink            in_ch,
	hps_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	hps_pkg::cfg_t cfg_q;
	hps_pkg::cmd_t cmd;
	hps_pkg::sts_t sts;

	assign pready = 1'b1;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols         <= 9'd64;
			cfg_q.rows         <= 13'd64;
			cfg_q.ambient      <= 16'd1280;
			cfg_q.cool_start   <= 8'd28;
			cfg_q.cool_end     <= 8'd35;
			cfg_q.inject_gain  <= 16'd3277;
			cfg_q.cool_gain    <= 16'd655;
			cfg_q.diffuse_gain <= 13'd6554;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				hps_pkg::RegCols:      cfg_q.cols         <= pwdata[8:0];
				hps_pkg::RegRows:      cfg_q.rows         <= pwdata[12:0];
				hps_pkg::RegAmbient:   cfg_q.ambient      <= pwdata[15:0];
				hps_pkg::RegCoolStart: cfg_q.cool_start   <= pwdata[7:0];
				hps_pkg::RegCoolEnd:   cfg_q.cool_end     <= pwdata[7:0];
				hps_pkg::RegInject:    cfg_q.inject_gain  <= pwdata[15:0];
				hps_pkg::RegCool:      cfg_q.cool_gain    <= pwdata[15:0];
				hps_pkg::RegDiffuse:   cfg_q.diffuse_gain <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr)
			hps_pkg::RegCols:      prdata = 32'(cfg_q.cols);
			hps_pkg::RegRows:      prdata = 32'(cfg_q.rows);
			hps_pkg::RegAmbient:   prdata = 32'(cfg_q.ambient);
			hps_pkg::RegCoolStart: prdata = 32'(cfg_q.cool_start);
			hps_pkg::RegCoolEnd:   prdata = 32'(cfg_q.cool_end);
			hps_pkg::RegInject:    prdata = 32'(cfg_q.inject_gain);
			hps_pkg::RegCool:      prdata = 32'(cfg_q.cool_gain);
			hps_pkg::RegDiffuse:   prdata = 32'(cfg_q.diffuse_gain);
			default:               prdata = 32'd0;
		endcase
	end

	// sequencer for one item at a time
	hps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd));

	// line buffers, window, gain arithmetic and result register
	hps_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .sts(sts),
		.cell_temp(in_ch.cell_temp), .chip_temp(in_ch.chip_temp),
		.new_temp(out_ch.new_temp), .cell_row(out_ch.cell_row),
		.cell_col(out_ch.cell_col), .running_sum(out_ch.running_sum),
		.last_cell(out_ch.last_cell));
endmodule

@@ tb/tb_top.sv @@
module tb_top;

	// register indexes, address is 4*index
	localparam int IdxCols      = 0;
	localparam int IdxRows      = 1;
	localparam int IdxAmbient   = 2;
	localparam int IdxCoolStart = 3;
	localparam int IdxCoolEnd   = 4;
	localparam int IdxInject    = 5;
	localparam int IdxCool      = 6;
	localparam int IdxDiffuse   = 7;
	localparam int NumRegs      = 8;

	localparam logic [hps_pkg::AddrBits-1:0] REG_ADDR [NumRegs] = '{hps_pkg::RegCols,
		hps_pkg::RegRows, hps_pkg::RegAmbient, hps_pkg::RegCoolStart, hps_pkg::RegCoolEnd,
		hps_pkg::RegInject, hps_pkg::RegCool, hps_pkg::RegDiffuse};
	localparam logic [31:0] REG_MASK [NumRegs] = '{32'h1FF, 32'h1FFF, 32'hFFFF, 32'hFF,
		32'hFF, 32'hFFFF, 32'hFFFF, 32'h1FFF};
	localparam logic [31:0] REG_RESET [NumRegs] = '{32'd64, 32'd64, 32'd1280, 32'd28,
		32'd35, 32'd3277, 32'd655, 32'd6554};

	localparam logic [63:0] TempMax = 64'hFFFF;
	localparam logic [63:0] SumMask = (64'd1 << hps_pkg::SumBits) - 64'd1;
	localparam int StimItems = 1750;
	localparam int DrainCycles = 12;

	typedef struct packed {
		logic [15:0] new_temp;
		logic [11:0] cell_row;
		logic [7:0]  cell_col;
		logic [36:0] running_sum;
		logic        last_cell;
	} cell_result_t;

	typedef struct {
		logic [15:0] cell_val;
		logic [15:0] chip;
		bit          typed;
		logic [15:0] temp;
		logic [36:0] sum;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	hps_in_if  in_ch ();
	hps_out_if out_ch ();

	heat_plate_stencil_step u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of the plate state
	logic [15:0] upper_mem [hps_pkg::MaxCols];
	logic [15:0] middle_mem [hps_pkg::MaxCols];
	logic [15:0] win [6];
	int          row_pos, col_pos;
	logic [63:0] sum_acc;
	logic [31:0] reg_val [NumRegs];
	logic [31:0] reg_next [NumRegs];

	cell_result_t result_q [$];
	int  errors;
	int  items_in;
	bit  burst;

	// 3x3 passes: all cold, all saturated hot, then a hot chip in the centre
	dir_row_t dir_tab [27] = '{
		'{16'h0000, 16'h0000, 0, 0, 0}, '{16'h0000, 16'h0000, 0, 0, 0},
		'{16'h0000, 16'h0000, 0, 0, 0}, '{16'h0000, 16'h0000, 0, 0, 0},
		'{16'h0000, 16'h0000, 0, 0, 0}, '{16'h0000, 16'h0000, 0, 0, 0},
		'{16'h0000, 16'h0000, 0, 0, 0}, '{16'h0000, 16'h0000, 0, 0, 0},
		'{16'h0000, 16'h0000, 1, 16'h0000, 37'h0},
		'{16'hFFFF, 16'hFFFF, 0, 0, 0}, '{16'hFFFF, 16'hFFFF, 0, 0, 0},
		'{16'hFFFF, 16'hFFFF, 0, 0, 0}, '{16'hFFFF, 16'hFFFF, 0, 0, 0},
		'{16'hFFFF, 16'hFFFF, 0, 0, 0}, '{16'hFFFF, 16'hFFFF, 0, 0, 0},
		'{16'hFFFF, 16'hFFFF, 0, 0, 0}, '{16'hFFFF, 16'hFFFF, 0, 0, 0},
		'{16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 37'hFFFF},
		'{16'h0100, 16'h0000, 0, 0, 0}, '{16'h0200, 16'hFFFF, 0, 0, 0},
		'{16'h0300, 16'h0000, 0, 0, 0}, '{16'h0400, 16'h0000, 0, 0, 0},
		'{16'h0500, 16'hFFFF, 0, 0, 0}, '{16'h0600, 16'h0000, 0, 0, 0},
		'{16'hFFFF, 16'h0000, 0, 0, 0}, '{16'h0001, 16'h8000, 0, 0, 0},
		'{16'h8000, 16'h0001, 0, 0, 0}
	};

	// clock, period 10
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rounded q0.16 product of a magnitude
	function automatic logic [63:0] round_gain(input logic [63:0] mag, input logic [63:0] g);
		return (mag * g + 64'd32768) >> 16;
	endfunction

	// value moved toward target by gain, saturated
	function automatic logic [63:0] toward(input logic [63:0] v, input logic [63:0] target,
			input logic [63:0] g);
		logic [63:0] r, d;
		if (target >= v) begin
			r = v + round_gain(target - v, g);
		end else begin
			d = round_gain(v - target, g);
			r = (d > v) ? 64'd0 : v - d;
		end
		return (r > TempMax) ? TempMax : r;
	endfunction

	task automatic reset_plate();
		for (int i = 0; i < hps_pkg::MaxCols; i++) begin
			upper_mem[i] = '0;
			middle_mem[i] = '0;
		end
		for (int i = 0; i < 6; i++) win[i] = '0;
		row_pos = 0;
		col_pos = 0;
		sum_acc = '0;
		for (int i = 0; i < NumRegs; i++) reg_val[i] = REG_RESET[i];
	endtask

	// one cell into the plate predictor
	task automatic heat_step(input logic [15:0] cell_val, input logic [15:0] chip,
			output bit has, output cell_result_t res);
		int cols, rows, r, c;
		logic [63:0] t, up, mid, ctr, s8, d, v;
		cols = reg_val[IdxCols];
		rows = reg_val[IdxRows];
		if (cols < 3) cols = 3;
		if (cols > hps_pkg::MaxCols) cols = hps_pkg::MaxCols;
		if (rows < 3) rows = 3;
		if (rows > 4096) rows = 4096;
		r = row_pos;
		c = col_pos;
		if (c >= cols) c = cols - 1;
		if (r >= rows) r = rows - 1;
		if (r == 0 && c == 0) sum_acc = '0;
		t = 64'(cell_val);
		if (r >= 1 && r <= rows - 2 && c >= 1 && c <= cols - 2) begin
			if (64'(chip) > t) t = toward(t, 64'(chip), 64'(reg_val[IdxInject]));
			if (c >= reg_val[IdxCoolStart] && c < reg_val[IdxCoolEnd])
				t = toward(t, 64'(reg_val[IdxAmbient]), 64'(reg_val[IdxCool]));
		end
		up = 64'(upper_mem[c]);
		mid = 64'(middle_mem[c]);
		has = 0;
		res = '0;
		if (r >= 2 && c >= 2) begin
			ctr = 64'(win[3]);
			s8 = 64'(win[0]) + 64'(win[1]) + up + 64'(win[2]) + mid + 64'(win[4])
				+ 64'(win[5]) + t;
			if (s8 >= 8 * ctr) begin
				v = ctr + round_gain(s8 - 8 * ctr, 64'(reg_val[IdxDiffuse]));
			end else begin
				d = round_gain(8 * ctr - s8, 64'(reg_val[IdxDiffuse]));
				v = (d > ctr) ? 64'd0 : ctr - d;
			end
			if (v > TempMax) v = TempMax;
			sum_acc = (sum_acc + v) & SumMask;
			res.new_temp = v[15:0];
			res.cell_row = 12'(r - 1);
			res.cell_col = 8'(c - 1);
			res.running_sum = sum_acc[36:0];
			res.last_cell = (r == rows - 1 && c == cols - 1);
			has = 1;
		end
		upper_mem[c] = mid[15:0];
		middle_mem[c] = t[15:0];
		win[0] = win[1];
		win[1] = up[15:0];
		win[2] = win[3];
		win[3] = mid[15:0];
		win[4] = win[5];
		win[5] = t[15:0];
		if (c >= cols - 1) begin
			c = 0;
			r = (r >= rows - 1) ? 0 : r + 1;
		end else begin
			c = c + 1;
		end
		row_pos = r;
		col_pos = c;
	endtask

	function automatic void flag(input string what, input logic [63:0] e, input logic [63:0] a);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, e, a);
	endfunction

	// apb write then read back
	task automatic reg_write(input int idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ADDR[idx];
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (v & REG_MASK[idx]))
			flag("register readback", 64'(v & REG_MASK[idx]), 64'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		reg_val[idx] = v & REG_MASK[idx];
	endtask

	// block idle: input withdrawn, no result pending, room for a cell still in flight
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_all();
		settle();
		for (int i = 0; i < NumRegs; i++) reg_write(i, reg_next[i]);
	endtask

	// drive one item, predict on acceptance
	task automatic send_cell(input logic [15:0] cell_val, input logic [15:0] chip,
			input bit typed, input logic [15:0] t_exp, input logic [36:0] s_exp);
		int gap;
		bit has;
		cell_result_t res;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cell_temp <= cell_val;
		in_ch.chip_temp <= chip;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		items_in++;
		heat_step(cell_val, chip, has, res);
		if (typed) begin
			res = '{t_exp, 12'd1, 8'd1, s_exp, 1'b1};
		end
		if (has) result_q.push_back(res);
	endtask

	task automatic random_cell();
		logic [15:0] cell_val, chip;
		cell_val = 16'($urandom);
		chip = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
		send_cell(cell_val, chip, 0, '0, '0);
	endtask

	// cells until the position wraps back to the first cell of a pass
	task automatic run_pass();
		do random_cell(); while (row_pos != 0 || col_pos != 0);
	endtask

	function automatic logic [31:0] pick_gain(input logic [31:0] top);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic random_setting();
		reg_next[IdxCols] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
			: $urandom_range(3, 12);
		reg_next[IdxRows] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
			: $urandom_range(3, 8);
		reg_next[IdxAmbient] = pick_gain(32'hFFFF);
		// band may be empty, reversed or reach past the grid
		reg_next[IdxCoolStart] = ($urandom_range(0, 9) == 0) ? 32'hFF : $urandom_range(0, 13);
		reg_next[IdxCoolEnd] = ($urandom_range(0, 9) == 0) ? 32'hFF : $urandom_range(0, 13);
		reg_next[IdxInject] = pick_gain(32'hFFFF);
		reg_next[IdxCool] = pick_gain(32'hFFFF);
		reg_next[IdxDiffuse] = pick_gain(32'h1FFF);
	endtask

	// result side: random stalls before each item
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	// checker, sampled at the edge
	always @(posedge clk) begin
		cell_result_t e;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (result_q.size() == 0) begin
				flag("unexpected item", 0, 64'(out_ch.new_temp));
			end else begin
				e = result_q.pop_front();
				if (out_ch.new_temp !== e.new_temp)
					flag("new_temp", 64'(e.new_temp), 64'(out_ch.new_temp));
				if (out_ch.cell_row !== e.cell_row)
					flag("cell_row", 64'(e.cell_row), 64'(out_ch.cell_row));
				if (out_ch.cell_col !== e.cell_col)
					flag("cell_col", 64'(e.cell_col), 64'(out_ch.cell_col));
				if (out_ch.running_sum !== e.running_sum)
					flag("running_sum", 64'(e.running_sum), 64'(out_ch.running_sum));
				if (out_ch.last_cell !== e.last_cell)
					flag("last_cell", 64'(e.last_cell), 64'(out_ch.last_cell));
			end
		end
	end

	// stimulus
	initial begin
		int cut;
		errors = 0;
		items_in = 0;
		burst = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cell_temp = '0;
		in_ch.chip_temp = '0;
		reset_plate();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// smallest grid, default gains
		for (int i = 0; i < NumRegs; i++) reg_next[i] = REG_RESET[i];
		reg_next[IdxCols] = 3;
		reg_next[IdxRows] = 3;
		write_all();
		for (int i = 0; i < 18; i++)
			send_cell(dir_tab[i].cell_val, dir_tab[i].chip, dir_tab[i].typed,
				dir_tab[i].temp, dir_tab[i].sum);
		// centre cell cooled hard toward a hot ambient, full gains
		reg_next[IdxCoolStart] = 1;
		reg_next[IdxCoolEnd] = 2;
		reg_next[IdxInject] = 32'hFFFF;
		reg_next[IdxCool] = 32'hFFFF;
		reg_next[IdxDiffuse] = 32'h1FFF;
		reg_next[IdxAmbient] = 32'hFFFF;
		write_all();
		for (int i = 18; i < 27; i++)
			send_cell(dir_tab[i].cell_val, dir_tab[i].chip, 0, '0, '0);

		// widest grid: column count above range clamps to the buffer depth
		random_setting();
		reg_next[IdxCols] = 32'h1FF;
		reg_next[IdxRows] = 3;
		write_all();
		run_pass();
		// tall grid: row count above range and column count below range clamp,
		// then the row count shrinks in mid pass
		burst = 1;
		random_setting();
		reg_next[IdxCols] = 0;
		reg_next[IdxRows] = 32'h1FFF;
		write_all();
		for (int i = 0; i < 45; i++) random_cell();
		reg_next[IdxRows] = 3;
		write_all();
		run_pass();
		burst = 0;

		while (items_in < StimItems) begin
			burst = ($urandom_range(0, 5) == 0);
			random_setting();
			write_all();
			if ($urandom_range(0, 3) == 0) begin
				// shrink the grid in mid pass, counters past the new size wrap
				cut = $urandom_range(1, 20);
				for (int i = 0; i < cut; i++) random_cell();
				if (row_pos != 0 || col_pos != 0) begin
					reg_next[IdxCols] = $urandom_range(0, reg_val[IdxCols] < 3 ? 3
						: reg_val[IdxCols]);
					reg_next[IdxRows] = $urandom_range(0, reg_val[IdxRows] < 3 ? 3
						: reg_val[IdxRows]);
					write_all();
					run_pass();
				end
			end else begin
				repeat ($urandom_range(1, 3)) run_pass();
			end
		end

		in_ch.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
